// ----- hdl/avt_pkg.sv -----
// ----------------------------------------------------------------------------
// avt_pkg
// Shared constants and helpers for the affine vector transform datapath.
// ----------------------------------------------------------------------------
package avt_pkg;

	localparam int FMA_LAT   = 5;
	localparam int ROW_LAT   = 3 * FMA_LAT;
	localparam int CFG_REGS  = 6;
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 64;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
	localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;

	typedef enum logic [CFG_AW-1:0] {
		REG_ROW0_A = 3'd0,
		REG_ROW0_B = 3'd1,
		REG_ROW1_A = 3'd2,
		REG_ROW1_B = 3'd3,
		REG_ROW2_A = 3'd4,
		REG_ROW2_B = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] m0;
		logic [31:0] m1;
		logic [31:0] m2;
		logic [31:0] m3;
	} row_coef_t;

	// position of the highest set bit, 0 when none
	function automatic logic [5:0] msb63(input logic [62:0] v);
		logic [5:0] k;
		k = 6'd0;
		for (int i = 0; i < 63; i++) begin
			if (v[i]) k = 6'(i);
		end
		return k;
	endfunction

	function automatic logic signed [11:0] exp_of(input logic [7:0] f);
		logic signed [11:0] e;
		e = (f == 8'd0) ? 12'sd1 : $signed({4'b0, f});
		return e - 12'sd150;
	endfunction

endpackage

// ----- hdl/avt_fma.sv -----
// ----------------------------------------------------------------------------
// avt_fma
// Five-stage binary32 fused multiply-add, a*b+c with one rounding (RNE).
// ----------------------------------------------------------------------------
module avt_fma import avt_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	output logic [31:0] y
);

	// stage 1: specials, product
	logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
	logic        ps, sc;
	logic        spec_c;
	logic [31:0] spec_v_c;

	assign a_nan  = (&a[30:23]) && (|a[22:0]);
	assign b_nan  = (&b[30:23]) && (|b[22:0]);
	assign c_nan  = (&c[30:23]) && (|c[22:0]);
	assign a_inf  = a[30:0] == INF_BITS[30:0];
	assign b_inf  = b[30:0] == INF_BITS[30:0];
	assign c_inf  = c[30:0] == INF_BITS[30:0];
	assign a_zero = a[30:0] == 31'd0;
	assign b_zero = b[30:0] == 31'd0;
	assign c_zero = c[30:0] == 31'd0;
	assign ps     = a[31] ^ b[31];
	assign sc     = c[31];

	always_comb begin
		spec_c   = 1'b1;
		spec_v_c = QNAN_BITS;
		priority if (a_nan || b_nan || c_nan) begin
			spec_v_c = QNAN_BITS;
		end else if (a_inf || b_inf) begin
			if (a_zero || b_zero) spec_v_c = QNAN_BITS;
			else if (c_inf && (sc != ps)) spec_v_c = QNAN_BITS;
			else spec_v_c = {ps, INF_BITS[30:0]};
		end else if (c_inf) begin
			spec_v_c = c;
		end else if (a_zero || b_zero) begin
			spec_v_c = c_zero ? {ps && sc, 31'd0} : c;
		end else begin
			spec_c = 1'b0;
		end
	end

	logic               spec_s1, cz_s1, ps_s1, sc_s1;
	logic [31:0]        sv_s1;
	logic [47:0]        pm_s1;
	logic signed [11:0] pe_s1, ce_s1;
	logic [23:0]        cm_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= spec_c;
			sv_s1   <= spec_v_c;
			cz_s1   <= c_zero;
			ps_s1   <= ps;
			sc_s1   <= sc;
			pm_s1   <= {|a[30:23], a[22:0]} * {|b[30:23], b[22:0]};
			pe_s1   <= exp_of(a[30:23]) + exp_of(b[30:23]);
			cm_s1   <= {|c[30:23], c[22:0]};
			ce_s1   <= exp_of(c[30:23]);
		end
	end

	// stage 2: normalize both operands to bit 61
	logic [5:0] shp, shc;
	assign shp = 6'd61 - msb63(63'(pm_s1));
	assign shc = 6'd61 - msb63(63'(cm_s1));

	logic               spec_s2, cz_s2, ps_s2, sc_s2;
	logic [31:0]        sv_s2;
	logic [61:0]        pm_s2, cm_s2;
	logic signed [11:0] pe_s2, ce_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2 <= spec_s1;
			sv_s2   <= sv_s1;
			cz_s2   <= cz_s1;
			ps_s2   <= ps_s1;
			sc_s2   <= sc_s1;
			pm_s2   <= 62'(pm_s1) << shp;
			cm_s2   <= 62'(cm_s1) << shc;
			pe_s2   <= pe_s1 - $signed({6'b0, shp});
			ce_s2   <= ce_s1 - $signed({6'b0, shc});
		end
	end

	// stage 3: order, align with sticky, add
	logic               p_big, sa, sb;
	logic [61:0]        am, bm, bal, mask;
	logic signed [11:0] ae, be, d;
	logic [62:0]        sum_c;

	always_comb begin
		p_big = (pe_s2 > ce_s2) || ((pe_s2 == ce_s2) && (pm_s2 >= cm_s2));
		if (p_big) begin
			am = pm_s2; ae = pe_s2; sa = ps_s2; bm = cm_s2; be = ce_s2; sb = sc_s2;
		end else begin
			am = cm_s2; ae = ce_s2; sa = sc_s2; bm = pm_s2; be = pe_s2; sb = ps_s2;
		end
		d    = ae - be;
		mask = ~({62{1'b1}} << d[5:0]);
		if (d >= 12'sd62) bal = 62'd1;
		else bal = (bm >> d[5:0]) | 62'(|(bm & mask));
		sum_c = (sa == sb) ? ({1'b0, am} + {1'b0, bal}) : ({1'b0, am} - {1'b0, bal});
		if (cz_s2) begin
			sum_c = {1'b0, pm_s2};
			ae    = pe_s2;
			sa    = ps_s2;
		end
	end

	logic               spec_s3, sg_s3;
	logic [31:0]        sv_s3;
	logic [62:0]        sum_s3;
	logic signed [11:0] e_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s3 <= spec_s2;
			sv_s3   <= sv_s2;
			sum_s3  <= sum_c;
			e_s3    <= ae;
			sg_s3   <= sa;
		end
	end

	// stage 4: leading one, rounding position
	logic signed [11:0] kk, lim;
	assign kk  = $signed({6'b0, msb63(sum_s3)}) - 12'sd23;
	assign lim = -12'sd149 - e_s3;

	logic               spec_s4, sg_s4;
	logic [31:0]        sv_s4;
	logic [62:0]        sum_s4;
	logic signed [11:0] e_s4, sh_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s4 <= spec_s3 || (sum_s3 == 63'd0);
			sv_s4   <= spec_s3 ? sv_s3 : 32'd0;
			sum_s4  <= sum_s3;
			e_s4    <= e_s3;
			sg_s4   <= sg_s3;
			sh_s4   <= (kk > lim) ? kk : lim;
		end
	end

	// stage 5: shift, round, pack
	logic [126:0]       ext;
	logic [62:0]        lsh;
	logic [24:0]        q;
	logic signed [11:0] neg_sh, bm1;
	logic [31:0]        bits, res_c;

	always_comb begin
		neg_sh = -sh_s4;
		ext    = {sum_s4, 64'd0} >> sh_s4[6:0];
		lsh    = sum_s4 << neg_sh[4:0];
		if (sh_s4 <= 12'sd0) begin
			q = lsh[24:0];
		end else begin
			q = ext[88:64] + 25'(ext[63] && ((|ext[62:0]) || ext[64]));
		end
		bm1  = e_s4 + sh_s4 + 12'sd149;
		bits = {1'b0, bm1[7:0], 23'd0} + {7'd0, q};
		if (bits >= INF_BITS) bits = INF_BITS;
		priority if (spec_s4) res_c = sv_s4;
		else if (sh_s4 > 12'sd64) res_c = {sg_s4, 31'd0};
		else if (bm1 > 12'sd254) res_c = {sg_s4, INF_BITS[30:0]};
		else res_c = {sg_s4, bits[30:0]};
	end

	always_ff @(posedge clk) begin
		if (en) y <= res_c;
	end

endmodule

// ----- hdl/avt_row.sv -----
// ----------------------------------------------------------------------------
// avt_row
// One matrix row: three levels of fused multiply-add units.
// ----------------------------------------------------------------------------
module avt_row import avt_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  row_coef_t   coef,
	input  logic        action,
	input  logic [31:0] vec_x,
	input  logic [31:0] vec_y,
	input  logic [31:0] vec_z,
	output logic [31:0] res
);

	logic        act_q [2*FMA_LAT];
	logic [31:0] z_q   [2*FMA_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			act_q[0] <= action;
			z_q[0]   <= vec_z;
			for (int i = 1; i < 2*FMA_LAT; i++) begin
				act_q[i] <= act_q[i-1];
				z_q[i]   <= z_q[i-1];
			end
		end
	end

	logic        act2, act3;
	logic [31:0] z2, z3;
	assign act2 = act_q[FMA_LAT-1];
	assign z2   = z_q[FMA_LAT-1];
	assign act3 = act_q[2*FMA_LAT-1];
	assign z3   = z_q[2*FMA_LAT-1];

	logic [31:0] p1, q1, p2, q2;

	avt_fma u_mul_x (.clk, .en, .a(coef.m0), .b(vec_x), .c(NEG_ZERO), .y(p1));
	avt_fma u_mul_y (.clk, .en, .a(coef.m1), .b(vec_y), .c(NEG_ZERO), .y(q1));

	avt_fma u_lv2_a (
		.clk, .en,
		.a(act2 ? p1 : coef.m2),
		.b(act2 ? ONE_BITS : z2),
		.c(act2 ? q1 : p1),
		.y(p2)
	);
	avt_fma u_lv2_b (.clk, .en, .a(coef.m3), .b(ONE_BITS), .c(q1), .y(q2));

	avt_fma u_lv3 (
		.clk, .en,
		.a(act3 ? coef.m2 : p2),
		.b(act3 ? z3 : ONE_BITS),
		.c(act3 ? p2 : q2),
		.y(res)
	);

endmodule

// ----- hdl/affine_vector_transform_float_top.sv -----
// ----------------------------------------------------------------------------
// affine_vector_transform_float_top
// 3x4 binary32 matrix times 3-vector, full affine or rotate/scale mode.
// ----------------------------------------------------------------------------
// One word per cycle in, one out, while the output is taken; each row runs
// three chained five-stage FMA levels. The whole pipeline advances together
// and holds when the output word is not taken. The user writes the matrix
// registers by index only while idle; the block itself does not enforce it.
module affine_vector_transform_float_top import avt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [CFG_DW-1:0]   cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [31:0]         vec_x,
	input  logic [31:0]         vec_y,
	input  logic [31:0]         vec_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_x,
	output logic [31:0]         out_y,
	output logic [31:0]         out_z
);

	logic [CFG_DW-1:0] cfg_q [CFG_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_ROW0_A] <= {ONE_BITS, 32'd0};
			cfg_q[REG_ROW0_B] <= '0;
			cfg_q[REG_ROW1_A] <= {32'd0, ONE_BITS};
			cfg_q[REG_ROW1_B] <= '0;
			cfg_q[REG_ROW2_A] <= '0;
			cfg_q[REG_ROW2_B] <= {ONE_BITS, 32'd0};
		end else if (cfg_wr_en && (cfg_addr <= REG_ROW2_B)) begin
			cfg_q[cfg_addr] <= cfg_wdata;
		end
	end

	logic en;
	logic vld_q [ROW_LAT];

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[ROW_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < ROW_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	row_coef_t coef0, coef1, coef2;
	assign coef0 = {cfg_q[REG_ROW0_A], cfg_q[REG_ROW0_B]};
	assign coef1 = {cfg_q[REG_ROW1_A], cfg_q[REG_ROW1_B]};
	assign coef2 = {cfg_q[REG_ROW2_A], cfg_q[REG_ROW2_B]};

	avt_row u_row0 (.clk, .en, .coef(coef0), .action, .vec_x, .vec_y, .vec_z, .res(out_x));
	avt_row u_row1 (.clk, .en, .coef(coef1), .action, .vec_x, .vec_y, .vec_z, .res(out_y));
	avt_row u_row2 (.clk, .en, .coef(coef2), .action, .vec_x, .vec_y, .vec_z, .res(out_z));

endmodule

// ----- tb/sv/tb_affine_vector_transform_float_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_vector_transform_float_top
// Drives vectors through the 3x4 binary32 transform under several matrices and
// both modes, predicts each output word with a bit-exact integer float model
// and checks results in order under random sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_affine_vector_transform_float_top;
	import avt_pkg::*;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} vec3_t;

	class transform_scoreboard;
		logic [63:0] mat[CFG_REGS];
		vec3_t pending[$];
		int errors;
		int checked;

		function int top_bit(logic [63:0] m);
			int k;
			k = 0;
			for (int i = 0; i < 64; i++) if (m[i]) k = i;
			return k;
		endfunction

		function logic [31:0] round_pack(logic s, logic [63:0] m, int e);
			int k, sh, lim, bexp;
			logic [63:0] q, rem, half;
			logic [31:0] bits;
			k = top_bit(m);
			sh = k - 23;
			lim = -149 - e;
			if (lim > sh) sh = lim;
			if (sh <= 0) begin
				q = m << (-sh);
			end else if (sh > 64) begin
				return {s, 31'd0};
			end else begin
				if (sh == 64) begin
					q = 0; rem = m; half = 64'h8000_0000_0000_0000;
				end else begin
					q = m >> sh;
					rem = m & ((64'd1 << sh) - 64'd1);
					half = 64'd1 << (sh - 1);
				end
				if (rem > half || (rem == half && q[0])) q = q + 1;
			end
			bexp = e + sh + 149;
			if (bexp > 254) return {s, 31'd0} | INF_BITS;
			bits = (32'(bexp) << 23) + q[31:0];
			if (bits >= INF_BITS) bits = INF_BITS;
			return {s, bits[30:0]};
		endfunction

		function bit is_nan(logic [31:0] v);
			return v[30:23] == 8'hFF && v[22:0] != 0;
		endfunction
		function bit is_inf(logic [31:0] v);
			return v[30:0] == INF_BITS[30:0];
		endfunction
		function bit is_zero(logic [31:0] v);
			return v[30:0] == 0;
		endfunction
		function logic [63:0] mant(logic [31:0] v);
			return {40'd0, v[30:23] != 0, v[22:0]};
		endfunction
		function int expo(logic [31:0] v);
			return (v[30:23] != 0 ? int'(v[30:23]) : 1) - 150;
		endfunction

		function logic [31:0] fused(logic [31:0] a, logic [31:0] b, logic [31:0] c);
			logic ps, sc, sa, sb;
			logic [63:0] pm, cm, am, bm, sum;
			int pe, ce, ae, be, d, sh;
			ps = a[31] ^ b[31];
			sc = c[31];
			if (is_nan(a) || is_nan(b) || is_nan(c)) return QNAN_BITS;
			if (is_inf(a) || is_inf(b)) begin
				if (is_zero(a) || is_zero(b)) return QNAN_BITS;
				if (is_inf(c) && sc != ps) return QNAN_BITS;
				return {ps, 31'd0} | INF_BITS;
			end
			if (is_inf(c)) return c;
			if (is_zero(a) || is_zero(b)) begin
				if (is_zero(c)) return (ps && sc) ? NEG_ZERO : 32'd0;
				return c;
			end
			pm = mant(a) * mant(b);
			pe = expo(a) + expo(b);
			if (is_zero(c)) return round_pack(ps, pm, pe);
			cm = mant(c);
			ce = expo(c);
			sh = 61 - top_bit(pm); pm = pm << sh; pe = pe - sh;
			sh = 61 - top_bit(cm); cm = cm << sh; ce = ce - sh;
			if (pe > ce || (pe == ce && pm >= cm)) begin
				am = pm; ae = pe; sa = ps; bm = cm; be = ce; sb = sc;
			end else begin
				am = cm; ae = ce; sa = sc; bm = pm; be = pe; sb = ps;
			end
			d = ae - be;
			if (d >= 62) bm = 1;
			else if (d > 0) bm = (bm >> d) | 64'((bm & ((64'd1 << d) - 1)) != 0);
			sum = (sa == sb) ? am + bm : am - bm;
			if (sum == 0) return 32'd0;
			return round_pack(sa, sum, ae);
		endfunction

		function vec3_t transform(logic act, vec3_t v);
			vec3_t o;
			logic [31:0] m0, m1, m2, m3, p, q, r;
			logic [31:0] res[3];
			for (int i = 0; i < 3; i++) begin
				m0 = mat[2*i][63:32]; m1 = mat[2*i][31:0];
				m2 = mat[2*i+1][63:32]; m3 = mat[2*i+1][31:0];
				p = fused(m0, v.x, NEG_ZERO);
				q = fused(m1, v.y, NEG_ZERO);
				if (!act) begin
					p = fused(m2, v.z, p);
					q = fused(m3, ONE_BITS, q);
					r = fused(p, ONE_BITS, q);
				end else begin
					r = fused(m2, v.z, fused(p, ONE_BITS, q));
				end
				res[i] = is_nan(r) ? QNAN_BITS : r;
			end
			o.x = res[0]; o.y = res[1]; o.z = res[2];
			return o;
		endfunction

		function void note_input(logic act, vec3_t v);
			pending.push_back(transform(act, v));
		endfunction

		function void check_result(vec3_t got);
			vec3_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected output word %h %h %h", got.x, got.y, got.z);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.x !== e.x) begin
				$error("out_x expected %h actual %h", e.x, got.x); errors++;
			end
			if (got.y !== e.y) begin
				$error("out_y expected %h actual %h", e.y, got.y); errors++;
			end
			if (got.z !== e.z) begin
				$error("out_z expected %h actual %h", e.z, got.z); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_wr_en, in_valid, in_ready, action, out_valid, out_ready;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;
	logic [31:0] vec_x, vec_y, vec_z, out_x, out_y, out_z;

	transform_scoreboard sb;
	int send_idle_pct, recv_idle_pct, sent_words, hold_cycles;
	longint cycles;

	affine_vector_transform_float_top dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) begin
			vec3_t g;
			g.x = out_x; g.y = out_y; g.z = out_z;
			sb.check_result(g);
		end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function logic [31:0] rand_float();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(9))
			0: v[30:23] = 8'hFF;
			1: v[30:23] = 8'h00;
			2: v[30:23] = 8'($urandom_range(1, 20));
			3: v[30:23] = 8'($urandom_range(230, 254));
			4: v[22:0] = 0;
			default: v[30:23] = 8'($urandom_range(100, 154));
		endcase
		return v;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_wr_en <= 1; cfg_addr <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 0;
		sb.mat[idx] = val;
	endtask

	task automatic send_word(logic act, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		vec3_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; action <= act; vec_x <= x; vec_y <= y; vec_z <= z;
		do @(posedge clk); while (!in_ready);
		v.x = x; v.y = y; v.z = z;
		sb.note_input(act, v);
		sent_words++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (ROW_LAT + 5) @(posedge clk);
	endtask

	task automatic random_matrix(bit extreme);
		cfg_idx_t idx;
		for (int i = 0; i < CFG_REGS; i++) begin
			idx = cfg_idx_t'(i);
			write_reg(idx, extreme ? {rand_float(), rand_float()} :
				{$urandom, $urandom} & 64'hBFFF_FFFF_BFFF_FFFF | 64'h3800_0000_3800_0000);
		end
	endtask

	task automatic random_words(int n);
		for (int i = 0; i < n; i++)
			send_word($urandom_range(1), rand_float(), rand_float(), rand_float());
	endtask

	initial begin
		logic [31:0] edges[8];
		sb = new();
		sb.mat = '{64'h3F80000000000000, 0, 64'h3F800000, 0, 0, 64'h3F80000000000000};
		edges = '{32'h0, NEG_ZERO, INF_BITS, 32'hFF800000, 32'h7F800001,
			32'h00000001, 32'h7F7FFFFF, 32'h807FFFFF};
		arst_n = 0; cfg_wr_en = 0; cfg_addr = 0; cfg_wdata = 0;
		in_valid = 0; action = 0; vec_x = 0; vec_y = 0; vec_z = 0; out_ready = 0;
		send_idle_pct = 16; recv_idle_pct = 88; hold_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset matrix, directed extremes
		for (int i = 0; i < 8; i++)
			send_word(i[0], edges[i], edges[7-i], edges[(i+3)%8]);
		send_word(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_word(1, ONE_BITS, ONE_BITS, ONE_BITS);
		drain();
		// cancellation and overflow with a hand-built matrix
		write_reg(REG_ROW0_A, {ONE_BITS, 32'hBF800000});
		write_reg(REG_ROW0_B, {32'h7F7FFFFF, 32'h0});
		write_reg(REG_ROW1_A, {32'h00800000, 32'h80000001});
		write_reg(REG_ROW1_B, {NEG_ZERO, NEG_ZERO});
		write_reg(REG_ROW2_A, {INF_BITS, 32'h0});
		write_reg(REG_ROW2_B, {32'h7F7FFFFF, 32'hFF7FFFFF});
		send_word(0, ONE_BITS, ONE_BITS, 32'h7F7FFFFF);
		send_word(1, 32'h40000000, 32'h40000000, NEG_ZERO);
		send_word(0, NEG_ZERO, NEG_ZERO, NEG_ZERO);
		send_word(1, 32'h3F000000, 32'h00000001, 32'h40000000);
		send_word(0, 32'h0, INF_BITS, ONE_BITS);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin send_idle_pct = 88; recv_idle_pct = 16; end
			if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
			drain();
			random_matrix(ph % 2);
			if (ph == 4) hold_cycles = 400;
			random_words(170);
		end
		drain();
		write_reg(cfg_idx_t'(0), 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(cfg_idx_t'(5), 64'h0);
		random_words(20);
		drain();

		$display("covered %0d words over several matrices, both modes, %0d outputs checked",
			sent_words, sb.checked);
		if (sb.errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/avt_pkg.sv
hdl/avt_fma.sv
hdl/avt_row.sv
hdl/affine_vector_transform_float_top.sv
tb/sv/tb_affine_vector_transform_float_top.sv
